>>> src/sgcd_pkg.sv
// shared types for the signed gcd unit
package sgcd_pkg;

    // status of the current operand pair, from the shared datapath unit to the sequencer
    typedef struct packed {
        logic a_zero;
        logic b_zero;
        logic a_odd;
        logic b_odd;
        logic a_ge_b;
    } t_flags;

endpackage

>>> src/sgcd_alu.sv
// shared compare and subtract unit for the gcd iteration
module sgcd_alu #(
    parameter int DATA_WIDTH = 32
) (
    input  logic [DATA_WIDTH-1:0] i_a,
    input  logic [DATA_WIDTH-1:0] i_b,
    output logic [DATA_WIDTH-1:0] o_diff,
    output sgcd_pkg::t_flags      o_flags
);
    import sgcd_pkg::*;

    logic                  w_ge;
    logic [DATA_WIDTH-1:0] w_lhs;
    logic [DATA_WIDTH-1:0] w_rhs;

    // larger minus smaller, so the difference is never negative
    assign w_ge   = (i_a >= i_b);
    assign w_lhs  = w_ge ? i_a : i_b;
    assign w_rhs  = w_ge ? i_b : i_a;
    assign o_diff = w_lhs - w_rhs;

    // operand status for the sequencer
    always_comb begin
        o_flags.a_zero = (i_a == '0);
        o_flags.b_zero = (i_b == '0);
        o_flags.a_odd  = i_a[0];
        o_flags.b_odd  = i_b[0];
        o_flags.a_ge_b = w_ge;
    end

endmodule

>>> src/sgcd_core.sv
// binary gcd sequencer: operand registers, common power-of-two count, step control
module sgcd_core #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [DATA_WIDTH-1:0] i_first,
    input  logic signed [DATA_WIDTH-1:0] i_second,
    input  logic                         i_take,
    output logic                         o_idle,
    output logic                         o_done,
    output logic [DATA_WIDTH-1:0]        o_result
);
    import sgcd_pkg::*;

    localparam int KW = $clog2(DATA_WIDTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [DATA_WIDTH-1:0] r_a, n_a;
    logic [DATA_WIDTH-1:0] r_b, n_b;
    logic [KW-1:0]         r_k, n_k;

    logic [DATA_WIDTH-1:0] w_diff;
    t_flags                w_flags;
    logic [DATA_WIDTH-1:0] w_mag_a;
    logic [DATA_WIDTH-1:0] w_mag_b;

    sgcd_alu #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_alu (
        .i_a    (r_a),
        .i_b    (r_b),
        .o_diff (w_diff),
        .o_flags(w_flags)
    );

    // operand magnitudes; the most negative value maps to 2^(W-1) as unsigned
    assign w_mag_a = i_first[DATA_WIDTH-1]  ? (~i_first + 1'b1)  : i_first;
    assign w_mag_b = i_second[DATA_WIDTH-1] ? (~i_second + 1'b1) : i_second;

    // one step of the binary gcd per cycle
    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_k     = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_a     = w_mag_a;
                    n_b     = w_mag_b;
                    n_k     = '0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                priority if (w_flags.a_zero) begin
                    n_a     = r_b << r_k;
                    n_state = S_DONE;
                end else if (w_flags.b_zero) begin
                    n_a     = r_a << r_k;
                    n_state = S_DONE;
                end else if (!w_flags.a_odd && !w_flags.b_odd) begin
                    n_a = r_a >> 1;
                    n_b = r_b >> 1;
                    n_k = r_k + 1'b1;
                end else if (!w_flags.a_odd) begin
                    n_a = r_a >> 1;
                end else if (!w_flags.b_odd) begin
                    n_b = r_b >> 1;
                end else if (w_flags.a_ge_b) begin
                    n_a = w_diff >> 1;
                end else begin
                    n_b = w_diff >> 1;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // operand registers
    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
        r_k <= n_k;
    end

    assign o_idle   = (r_state == S_IDLE);
    assign o_done   = (r_state == S_DONE);
    assign o_result = r_a;

endmodule

>>> src/signed_gcd_unit.sv
// signed gcd unit: binary gcd of operand magnitudes over one shared compare/subtract unit
// the core runs a data-dependent number of binary gcd steps, then hands the result off
//   to the output register
// the unit holds one transaction at a time and accepts no new one until the core is idle
//   again after the result hand-off
// reset: synchronous active low, clears the sequencer and the output valid flag
module signed_gcd_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [DATA_WIDTH-1:0] i_first_value,
    input  logic signed [DATA_WIDTH-1:0] i_second_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [DATA_WIDTH-1:0]        o_divisor
);
    import sgcd_pkg::*;

    logic                  w_start;
    logic                  w_idle;
    logic                  w_done;
    logic                  w_take;
    logic [DATA_WIDTH-1:0] w_result;
    logic                  r_out_valid, n_out_valid;
    logic [DATA_WIDTH-1:0] r_divisor;

    // input transaction starts the core when it is idle
    assign o_in_stall = !w_idle;
    assign w_start    = i_in_valid && !o_in_stall;

    sgcd_core #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_first (i_first_value),
        .i_second(i_second_value),
        .i_take  (w_take),
        .o_idle  (w_idle),
        .o_done  (w_done),
        .o_result(w_result)
    );

    // output register takes the result once it is free or being drained
    assign w_take = w_done && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_take) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_divisor <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_divisor   = r_divisor;

    // a started transaction keeps the input stalled on the next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> o_in_stall)
        else $error("core accepted a transaction but did not go busy");

    // the output register is loaded only from a finished core result
    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out_valid && !r_out_valid) |-> w_done)
        else $error("output valid rose without a finished result");

    // handing off the result frees the core for the next transaction
    a_take_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> w_idle)
        else $error("core not idle after result hand-off");

    // the core never finishes while idle
    a_done_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_done && w_idle))
        else $error("core reports done and idle together");

endmodule
